// ===== rtl/core/mntd_pkg.sv =====
// ----------------------------------------------------------------------------
// mntd_pkg
// Type codes and shared types for the numeric-to-double converter.
// ----------------------------------------------------------------------------
`default_nettype none
package mntd_pkg;
    localparam logic [15:0] TC_INT8   = 16'd1;
    localparam logic [15:0] TC_UINT8  = 16'd2;
    localparam logic [15:0] TC_INT16  = 16'd3;
    localparam logic [15:0] TC_UINT16 = 16'd4;
    localparam logic [15:0] TC_INT32  = 16'd5;
    localparam logic [15:0] TC_UINT32 = 16'd6;
    localparam logic [15:0] TC_SINGLE = 16'd7;
    localparam logic [15:0] TC_DOUBLE = 16'd9;
    localparam logic [15:0] TC_INT64  = 16'd12;
    localparam logic [15:0] TC_UINT64 = 16'd13;
    localparam logic [15:0] TC_UTF8   = 16'd16;

    localparam logic [1:0] K_INT  = 2'd0;
    localparam logic [1:0] K_PASS = 2'd1;
    localparam logic [1:0] K_ZERO = 2'd2;

    // Item after decode: magnitude to normalize or a finished pattern.
    typedef struct packed {
        logic [1:0]  kind;
        logic        neg;
        logic [63:0] mag;
        logic [10:0] exp_adj;
        logic [63:0] bits;
        logic        status;
        logic        last;
    } t_dec;

    // Item after normalization.
    typedef struct packed {
        logic [1:0]  kind;
        logic        neg;
        logic [63:0] norm;
        logic [10:0] expo;
        logic [63:0] bits;
        logic        status;
        logic        last;
    } t_nrm;
endpackage
`default_nettype wire

// ===== rtl/core/mntd_decode.sv =====
// ----------------------------------------------------------------------------
// mntd_decode
// Select the type, extract sign and magnitude, form single/double patterns.
// ----------------------------------------------------------------------------
`default_nettype none
module mntd_decode (
    input  wire logic [15:0]     i_data_type,
    input  wire logic [63:0]     i_raw_value,
    input  wire logic            i_last,
    output mntd_pkg::t_dec       o_dec
);
    import mntd_pkg::*;

    logic [63:0] v_mag;
    logic [7:0]  v_ex;
    logic [22:0] v_fr;
    logic        v_sgn;

    always_comb begin
        v_sgn = i_raw_value[31];
        v_ex  = i_raw_value[30:23];
        v_fr  = i_raw_value[22:0];
        v_mag = '0;
        o_dec = '0;
        o_dec.last = i_last;
        o_dec.kind = K_INT;
        o_dec.exp_adj = 11'd1023;
        unique case (i_data_type)
            TC_INT8: begin
                o_dec.neg = i_raw_value[7];
                v_mag = {{56{i_raw_value[7]}}, i_raw_value[7:0]};
            end
            TC_UINT8, TC_UTF8: v_mag = {56'd0, i_raw_value[7:0]};
            TC_INT16: begin
                o_dec.neg = i_raw_value[15];
                v_mag = {{48{i_raw_value[15]}}, i_raw_value[15:0]};
            end
            TC_UINT16: v_mag = {48'd0, i_raw_value[15:0]};
            TC_INT32: begin
                o_dec.neg = i_raw_value[31];
                v_mag = {{32{i_raw_value[31]}}, i_raw_value[31:0]};
            end
            TC_UINT32: v_mag = {32'd0, i_raw_value[31:0]};
            TC_INT64: begin
                o_dec.neg = i_raw_value[63];
                v_mag = i_raw_value;
            end
            TC_UINT64: v_mag = i_raw_value;
            TC_DOUBLE: begin
                o_dec.kind = K_PASS;
                o_dec.bits = i_raw_value;
            end
            TC_SINGLE: begin
                o_dec.neg = v_sgn;
                if (v_ex == 8'hFF) begin
                    o_dec.kind = K_PASS;
                    o_dec.bits = {v_sgn, 11'h7FF, 52'd0};
                    if (v_fr != 23'd0) begin
                        o_dec.bits[51:29] = v_fr | 23'h400000;
                    end
                end else if (v_ex == 8'd0) begin
                    // subnormal: value fr * 2^-149 -> exp = p + 874
                    v_mag = {41'd0, v_fr};
                    o_dec.exp_adj = 11'd874;
                end else begin
                    o_dec.kind = K_PASS;
                    o_dec.bits = {v_sgn, 11'({3'd0, v_ex} + 11'd896), v_fr, 29'd0};
                end
            end
            default: begin
                o_dec.kind = K_ZERO;
                o_dec.status = 1'b1;
            end
        endcase
        if (o_dec.neg && o_dec.kind == K_INT && o_dec.exp_adj == 11'd1023) begin
            v_mag = 64'(0 - v_mag);
        end
        o_dec.mag = v_mag;
    end
endmodule
`default_nettype wire

// ===== rtl/core/mntd_norm.sv =====
// ----------------------------------------------------------------------------
// mntd_norm
// Find the leading one and shift the magnitude to bit 63.
// ----------------------------------------------------------------------------
`default_nettype none
module mntd_norm (
    input  wire mntd_pkg::t_dec  i_dec,
    output mntd_pkg::t_nrm       o_nrm
);
    import mntd_pkg::*;

    logic [63:0] v_m;
    logic [6:0]  v_lz;

    always_comb begin
        v_m  = i_dec.mag;
        v_lz = '0;
        if (v_m[63:32] == '0) begin v_m = v_m << 32; v_lz[5] = 1'b1; end
        if (v_m[63:48] == '0) begin v_m = v_m << 16; v_lz[4] = 1'b1; end
        if (v_m[63:56] == '0) begin v_m = v_m << 8;  v_lz[3] = 1'b1; end
        if (v_m[63:60] == '0) begin v_m = v_m << 4;  v_lz[2] = 1'b1; end
        if (v_m[63:62] == '0) begin v_m = v_m << 2;  v_lz[1] = 1'b1; end
        if (v_m[63] == 1'b0)  begin v_m = v_m << 1;  v_lz[0] = 1'b1; end
        o_nrm.kind   = i_dec.kind;
        o_nrm.neg    = i_dec.neg;
        o_nrm.norm   = v_m;
        o_nrm.expo   = 11'(i_dec.exp_adj + 11'd63 - {4'd0, v_lz});
        o_nrm.bits   = i_dec.bits;
        o_nrm.status = i_dec.status;
        o_nrm.last   = i_dec.last;
    end
endmodule
`default_nettype wire

// ===== rtl/core/mntd_round.sv =====
// ----------------------------------------------------------------------------
// mntd_round
// Round the normalized magnitude to 53 bits, nearest even, and pack.
// ----------------------------------------------------------------------------
`default_nettype none
module mntd_round (
    input  wire mntd_pkg::t_nrm  i_nrm,
    output logic [63:0]          o_bits
);
    import mntd_pkg::*;

    logic [53:0] v_keep;
    logic        v_g;
    logic        v_s;
    logic        v_up;
    logic [10:0] v_e;

    always_comb begin
        v_g  = i_nrm.norm[10];
        v_s  = |i_nrm.norm[9:0];
        v_up = v_g && (v_s || i_nrm.norm[11]);
        v_keep = {1'b0, i_nrm.norm[63:11]} + {53'd0, v_up};
        v_e = i_nrm.expo;
        if (v_keep[53]) begin
            v_e = 11'(v_e + 11'd1);
        end
        unique case (i_nrm.kind)
            K_INT: begin
                if (i_nrm.norm[63] == 1'b0) begin
                    o_bits = {i_nrm.neg, 63'd0};
                end else if (v_keep[53]) begin
                    o_bits = {i_nrm.neg, v_e, v_keep[52:1]};
                end else begin
                    o_bits = {i_nrm.neg, v_e, v_keep[51:0]};
                end
            end
            K_PASS:  o_bits = i_nrm.bits;
            default: o_bits = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/mat_numeric_to_double_core.sv =====
// ----------------------------------------------------------------------------
// mat_numeric_to_double_core
// Widen one MAT v5 numeric sample to an IEEE-754 double bit pattern.
// ----------------------------------------------------------------------------
// Three register stages: decode, normalize, and round into the output
// register. One transaction per cycle unless stalled; an accepted input passes
// the decode, normalize and output registers in turn. The stages advance
// whenever the output register is free or being taken, so a stall holds all.
// ----------------------------------------------------------------------------
`default_nettype none
module mat_numeric_to_double_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [87:0] s_axis_tdata,  // data_type[15:0], raw_value[79:16]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // double_bits[63:0]
    output logic             m_axis_tuser,  // status
    output logic             m_axis_tlast
);
    import mntd_pkg::*;

    logic   w_adv;
    t_dec   w_dec;
    t_nrm   w_nrm;
    logic [63:0] w_bits;
    t_dec   r_s1;
    t_nrm   r_s2;
    logic   r_v1, r_v2;

    assign w_adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    mntd_decode u_dec (
        .i_data_type (s_axis_tdata[15:0]),
        .i_raw_value (s_axis_tdata[79:16]),
        .i_last      (s_axis_tlast),
        .o_dec       (w_dec)
    );
    mntd_norm u_norm (.i_dec(r_s1), .o_nrm(w_nrm));
    mntd_round u_rnd (.i_nrm(r_s2), .o_bits(w_bits));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            m_axis_tvalid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= w_dec;
            r_s2 <= w_nrm;
            m_axis_tdata <= w_bits;
            m_axis_tuser <= r_s2.status;
            m_axis_tlast <= r_s2.last;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
        else $error("unsupported type gave nonzero data");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && w_adv |=> m_axis_tvalid)
        else $error("item lost at output");
endmodule
`default_nettype wire
